### sv/jdcd_pkg.sv
// ----------------------------------------------------------------------------
// jdcd_pkg
// Constants and types for the Julian Day to calendar date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package jdcd_pkg;

  localparam int STAGES = 16;

  localparam logic [16:0] HALF_DAY   = 17'd43200;
  localparam logic [16:0] DAY_LAST   = 17'd86399;
  localparam logic [23:0] GREG_START = 24'd2299161;

  // Century correction: a1 = (4z - A1_OFS) / A1_DIV.
  localparam logic [25:0] A1_OFS   = 26'd7468865;
  localparam logic [24:0] A1_DIV   = 25'd146097;
  localparam logic [7:0]  A1_RECIP = 8'd229;

  localparam logic [23:0] B_OFS = 24'd1524;

  // Year count: c = (20b - C_OFS) / C_DIV.
  localparam logic [27:0] C_OFS   = 28'd2442;
  localparam logic [27:0] C_DIV   = 28'd7305;
  localparam logic [15:0] C_RECIP = 16'd36746;

  localparam logic [10:0] D_MUL = 11'd1461;

  // Month count: e = 10000 (b - d) / E_DIV.
  localparam logic [13:0] E_MUL   = 14'd10000;
  localparam logic [22:0] E_DIV   = 23'd306001;
  localparam logic [4:0]  E_RECIP = 5'd27;

  localparam logic [16:0] HOUR_SECS  = 17'd3600;
  localparam logic [5:0]  HOUR_RECIP = 6'd36;
  localparam logic [11:0] MIN_SECS   = 12'd60;
  localparam logic [6:0]  MIN_RECIP  = 7'd68;

  localparam logic signed [15:0] YEAR_OFS_LATE  = 16'sd4716;
  localparam logic signed [15:0] YEAR_OFS_EARLY = 16'sd4715;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  // Packed so that year sits in the lowest bits of the output word.
  typedef struct packed {
    logic [5:0]         second;
    logic [5:0]         minute;
    logic [4:0]         hour;
    logic [4:0]         day_of_month;
    logic [3:0]         month;
    logic signed [15:0] year;
  } result_t;

  // Days before the start of the month with index e, floor(30.6001 e).
  function automatic logic [8:0] month_start(input logic [3:0] e);
    logic [8:0] v;
    case (e)
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd183;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd244;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd336;
      4'd12:   v = 9'd367;
      4'd13:   v = 9'd397;
      4'd14:   v = 9'd428;
      4'd15:   v = 9'd459;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/julian_day_to_calendar_date.sv
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date
// Converts a Julian Day (whole days plus seconds after noon) to a Gregorian
// or Julian calendar date and the time of day, after the Meeus method.
// ----------------------------------------------------------------------------
//  Channel  Direction  Data
//  in_      sink       jd_days, seconds_from_noon
//  out_     source     year, month, day_of_month, hour, minute, second
//
//  One transaction is taken per cycle while the output queue is not full. The
//  pipeline depth is set by the three constant divisions, each a reciprocal
//  multiply, a back multiply and a correcting compare.
//  A two-entry output queue lets a result wait while input is still taken;
//  the pipeline holds whenever that queue is full.
//  Reset clears the stage valid bits and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module julian_day_to_calendar_date (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // jd_days, seconds_from_noon
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // year, month, day_of_month, hour, minute, second
);

  import jdcd_pkg::*;

  logic                adv;
  logic [STAGES-1:0]   stg_vld_r;

  // Stage registers.
  logic [23:0] s1_z_r;
  logic [16:0] s1_t_r;
  logic [23:0] s2_z_r;
  logic        s2_greg_r;
  logic [24:0] s2_na_r;
  logic [16:0] s2_t_r;
  logic [21:0] s2_ph_r;
  logic [23:0] s3_z_r;
  logic        s3_greg_r;
  logic [24:0] s3_na_r;
  logic [32:0] s3_pa_r;
  logic [16:0] s3_t_r;
  logic [4:0]  s3_qh_r;
  logic [16:0] s3_qhd_r;
  logic [23:0] s4_z_r;
  logic        s4_greg_r;
  logic [24:0] s4_na_r;
  logic [7:0]  s4_qa_r;
  logic [24:0] s4_qad_r;
  logic [4:0]  s4_hour_r;
  logic [11:0] s4_remh_r;
  logic [23:0] s5_z_r;
  logic        s5_greg_r;
  logic [7:0]  s5_a1_r;
  logic [4:0]  s5_hour_r;
  logic [11:0] s5_remh_r;
  logic [17:0] s5_pm_r;
  logic [23:0] s6_b_r;
  logic [4:0]  s6_hour_r;
  logic [11:0] s6_remh_r;
  logic [5:0]  s6_qm_r;
  logic [11:0] s6_qmd_r;
  logic [23:0] s7_b_r;
  logic [27:0] s7_nc_r;
  logic [23:0] s8_b_r;
  logic [27:0] s8_nc_r;
  logic [42:0] s8_pc_r;
  logic [23:0] s9_b_r;
  logic [27:0] s9_nc_r;
  logic [14:0] s9_qc_r;
  logic [27:0] s9_qcd_r;
  logic [23:0] s10_b_r;
  logic [14:0] s10_c_r;
  logic [23:0] s11_b_r;
  logic [14:0] s11_c_r;
  logic [23:0] s11_d_r;
  logic [14:0] s12_c_r;
  logic [8:0]  s12_bd_r;
  logic [14:0] s13_c_r;
  logic [8:0]  s13_bd_r;
  logic [22:0] s13_ne_r;
  logic [14:0] s14_c_r;
  logic [8:0]  s14_bd_r;
  logic [22:0] s14_ne_r;
  logic [27:0] s14_pe_r;
  logic [14:0] s15_c_r;
  logic [8:0]  s15_bd_r;
  logic [22:0] s15_ne_r;
  logic [4:0]  s15_qe_r;
  logic [22:0] s15_qed_r;
  logic [14:0] s16_c_r;
  logic [8:0]  s16_bd_r;
  logic [3:0]  s16_e_r;
  hms_t        hms_r [7:STAGES];

  // Next values.
  logic [16:0] sec_in;
  logic [16:0] sec_sat;
  logic        late;
  logic [23:0] s1_z_nxt;
  logic [16:0] s1_t_nxt;
  logic        s2_greg_nxt;
  logic [25:0] na_full;
  logic [22:0] ph_full;
  logic [32:0] s3_pa_nxt;
  logic [16:0] s3_qhd_nxt;
  logic [24:0] s4_qad_nxt;
  logic [16:0] rh;
  logic        hcarry;
  logic [16:0] remh_full;
  logic [4:0]  s4_hour_nxt;
  logic [24:0] ra;
  logic [7:0]  s5_a1_nxt;
  logic [18:0] pm_full;
  logic [23:0] s6_b_nxt;
  logic [11:0] s6_qmd_nxt;
  logic [27:0] s7_nc_nxt;
  logic [11:0] rm;
  logic        mcarry;
  logic [11:0] sec_full;
  hms_t        hms_nxt;
  logic [43:0] pc_full;
  logic [27:0] s9_qcd_nxt;
  logic [27:0] rc;
  logic [14:0] s10_c_nxt;
  logic [25:0] dp_full;
  logic [23:0] bd_full;
  logic [22:0] s13_ne_nxt;
  logic [27:0] s14_pe_nxt;
  logic [22:0] s15_qed_nxt;
  logic [22:0] re;
  logic [4:0]  e_full;

  // Result and output queue.
  result_t     res;
  logic [8:0]  dom_full;
  result_t     q0_r, q0_nxt;
  result_t     q1_r, q1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign adv       = (cnt_r != 2'd2);
  assign in_tready = adv;

  always_comb begin
    sec_in   = in_tdata[39:23];
    sec_sat  = (sec_in > DAY_LAST) ? DAY_LAST : sec_in;
    late     = (sec_sat >= HALF_DAY);
    s1_z_nxt = {1'b0, in_tdata[22:0]} + {23'd0, late};
    s1_t_nxt = late ? (sec_sat - HALF_DAY) : (sec_sat + HALF_DAY);
  end

  always_comb begin
    s2_greg_nxt = (s1_z_r >= GREG_START);
    na_full     = {s1_z_r, 2'b00} - A1_OFS;
    ph_full     = s1_t_r * HOUR_RECIP;
    s3_pa_nxt   = s2_na_r * A1_RECIP;
    s3_qhd_nxt  = s2_ph_r[21:17] * HOUR_SECS;
    s4_qad_nxt  = s3_pa_r[32:25] * A1_DIV;
    rh          = s3_t_r - s3_qhd_r;
    hcarry      = (rh >= HOUR_SECS);
    remh_full   = hcarry ? (rh - HOUR_SECS) : rh;
    s4_hour_nxt = s3_qh_r + {4'd0, hcarry};
    ra          = s4_na_r - s4_qad_r;
    s5_a1_nxt   = s4_qa_r + {7'd0, (ra >= A1_DIV)};
    pm_full     = s4_remh_r * MIN_RECIP;
  end

  always_comb begin
    if (s5_greg_r) begin
      s6_b_nxt = s5_z_r + 24'd1 + {16'd0, s5_a1_r} - {18'd0, s5_a1_r[7:2]} + B_OFS;
    end else begin
      s6_b_nxt = s5_z_r + B_OFS;
    end
    s6_qmd_nxt = s5_pm_r[17:12] * MIN_SECS;
    s7_nc_nxt  = {s6_b_r, 4'b0000} + {2'b00, s6_b_r, 2'b00} - C_OFS;
    rm         = s6_remh_r - s6_qmd_r;
    mcarry     = (rm >= MIN_SECS);
    sec_full   = mcarry ? (rm - MIN_SECS) : rm;
    hms_nxt.hour   = s6_hour_r;
    hms_nxt.minute = s6_qm_r + {5'd0, mcarry};
    hms_nxt.second = sec_full[5:0];
  end

  always_comb begin
    pc_full     = s7_nc_r * C_RECIP;
    s9_qcd_nxt  = s8_pc_r[42:28] * C_DIV;
    rc          = s9_nc_r - s9_qcd_r;
    s10_c_nxt   = s9_qc_r + {14'd0, (rc >= C_DIV)};
    dp_full     = s10_c_r * D_MUL;
    bd_full     = s11_b_r - s11_d_r;
    s13_ne_nxt  = s12_bd_r * E_MUL;
    s14_pe_nxt  = s13_ne_r * E_RECIP;
    s15_qed_nxt = s14_pe_r[27:23] * E_DIV;
    re          = s15_ne_r - s15_qed_r;
    e_full      = s15_qe_r + {4'd0, (re >= E_DIV)};
  end

  always_comb begin
    dom_full         = s16_bd_r - month_start(s16_e_r);
    res.day_of_month = dom_full[4:0];
    res.month        = (s16_e_r < 4'd14) ? (s16_e_r - 4'd1) : (s16_e_r - 4'd13);
    if (res.month > 4'd2) begin
      res.year = $signed({1'b0, s16_c_r}) - YEAR_OFS_LATE;
    end else begin
      res.year = $signed({1'b0, s16_c_r}) - YEAR_OFS_EARLY;
    end
    res.hour   = hms_r[STAGES].hour;
    res.minute = hms_r[STAGES].minute;
    res.second = hms_r[STAGES].second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else if (adv) begin
      stg_vld_r <= {stg_vld_r[STAGES-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_z_r    <= s1_z_nxt;
      s1_t_r    <= s1_t_nxt;
      s2_z_r    <= s1_z_r;
      s2_greg_r <= s2_greg_nxt;
      s2_na_r   <= na_full[24:0];
      s2_t_r    <= s1_t_r;
      s2_ph_r   <= ph_full[21:0];
      s3_z_r    <= s2_z_r;
      s3_greg_r <= s2_greg_r;
      s3_na_r   <= s2_na_r;
      s3_pa_r   <= s3_pa_nxt;
      s3_t_r    <= s2_t_r;
      s3_qh_r   <= s2_ph_r[21:17];
      s3_qhd_r  <= s3_qhd_nxt;
      s4_z_r    <= s3_z_r;
      s4_greg_r <= s3_greg_r;
      s4_na_r   <= s3_na_r;
      s4_qa_r   <= s3_pa_r[32:25];
      s4_qad_r  <= s4_qad_nxt;
      s4_hour_r <= s4_hour_nxt;
      s4_remh_r <= remh_full[11:0];
      s5_z_r    <= s4_z_r;
      s5_greg_r <= s4_greg_r;
      s5_a1_r   <= s5_a1_nxt;
      s5_hour_r <= s4_hour_r;
      s5_remh_r <= s4_remh_r;
      s5_pm_r   <= pm_full[17:0];
      s6_b_r    <= s6_b_nxt;
      s6_hour_r <= s5_hour_r;
      s6_remh_r <= s5_remh_r;
      s6_qm_r   <= s5_pm_r[17:12];
      s6_qmd_r  <= s6_qmd_nxt;
      s7_b_r    <= s6_b_r;
      s7_nc_r   <= s7_nc_nxt;
      s8_b_r    <= s7_b_r;
      s8_nc_r   <= s7_nc_r;
      s8_pc_r   <= pc_full[42:0];
      s9_b_r    <= s8_b_r;
      s9_nc_r   <= s8_nc_r;
      s9_qc_r   <= s8_pc_r[42:28];
      s9_qcd_r  <= s9_qcd_nxt;
      s10_b_r   <= s9_b_r;
      s10_c_r   <= s10_c_nxt;
      s11_b_r   <= s10_b_r;
      s11_c_r   <= s10_c_r;
      s11_d_r   <= dp_full[25:2];
      s12_c_r   <= s11_c_r;
      s12_bd_r  <= bd_full[8:0];
      s13_c_r   <= s12_c_r;
      s13_bd_r  <= s12_bd_r;
      s13_ne_r  <= s13_ne_nxt;
      s14_c_r   <= s13_c_r;
      s14_bd_r  <= s13_bd_r;
      s14_ne_r  <= s13_ne_r;
      s14_pe_r  <= s14_pe_nxt;
      s15_c_r   <= s14_c_r;
      s15_bd_r  <= s14_bd_r;
      s15_ne_r  <= s14_ne_r;
      s15_qe_r  <= s14_pe_r[27:23];
      s15_qed_r <= s15_qed_nxt;
      s16_c_r   <= s15_c_r;
      s16_bd_r  <= s15_bd_r;
      s16_e_r   <= e_full[3:0];
      hms_r[7]  <= hms_nxt;
      for (int i = 8; i <= STAGES; i++) begin
        hms_r[i] <= hms_r[i-1];
      end
    end
  end

  // Two-entry output queue; q0 is the head.
  assign push       = adv && stg_vld_r[STAGES-1];
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          q0_nxt = res;
        end else begin
          q1_nxt = res;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        q0_nxt  = q1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          q0_nxt = res;
        end else begin
          q0_nxt = q1_r;
          q1_nxt = res;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_tdata = {6'd0, q0_r};

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (q0_r.month >= 4'd1) && (q0_r.month <= 4'd12) &&
                   (q0_r.day_of_month >= 5'd1))
    else $error("month or day of month out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (q0_r.hour <= 5'd23) && (q0_r.minute <= 6'd59) &&
                   (q0_r.second <= 6'd59))
    else $error("time of day out of range");

  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r[STAGES-1] && !in_tready) |=> stg_vld_r[STAGES-1])
    else $error("last pipeline stage dropped a result while held");
`endif

endmodule

`default_nettype wire

### dv/jdcd_date_monitor.sv
// ----------------------------------------------------------------------------
// jdcd_date_monitor
// Watches both stream channels of the Julian Day converter. It works out the
// calendar date and time of day of every input transaction and compares each
// output transaction, field by field, with the oldest date still owed.
// ----------------------------------------------------------------------------
module jdcd_date_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // jd_days, seconds_from_noon
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // year, month, day_of_month, hour, minute, second
  output int          failures,
  output int          outstanding,
  output int          dates_checked
);

  import jdcd_pkg::*;

  localparam longint DAY_SECS      = 86400;
  localparam longint NOON_SECS     = 43200;
  localparam longint GREGORIAN_DAY = 2299161;

  result_t owed_dates[$];

  initial begin
    failures      = 0;
    outstanding   = 0;
    dates_checked = 0;
  end

  function automatic result_t civil_date_of(input logic [22:0] jd, input logic [16:0] secs);
    longint  z, s, a, a1, b, c, d, e, mon, yr, dom;
    result_t r;
    z = longint'(jd);
    s = longint'(secs);
    if (s > DAY_SECS - 1) begin
      s = DAY_SECS - 1;
    end
    if (s >= NOON_SECS) begin
      z = z + 1;
      s = s - NOON_SECS;
    end else begin
      s = s + NOON_SECS;
    end
    if (z < GREGORIAN_DAY) begin
      a = z;
    end else begin
      a1 = (4 * z - 7468865) / 146097;
      a  = z + 1 + a1 - a1 / 4;
    end
    b   = a + 1524;
    c   = (20 * b - 2442) / 7305;
    d   = (1461 * c) / 4;
    e   = (10000 * (b - d)) / 306001;
    dom = b - d - (306001 * e) / 10000;
    mon = (e < 14) ? e - 1 : e - 13;
    yr  = (mon > 2) ? c - 4716 : c - 4715;
    r.year         = yr[15:0];
    r.month        = mon[3:0];
    r.day_of_month = dom[4:0];
    r.hour         = 5'(s / 3600);
    r.minute       = 6'((s / 60) % 60);
    r.second       = 6'(s % 60);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at date %0d: %s is %0d, expected %0d", dates_checked, what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      owed_dates.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        owed_dates.push_back(civil_date_of(in_tdata[22:0], in_tdata[39:23]));
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[41:0]);
        if (owed_dates.size() == 0) begin
          report_mismatch("unexpected transaction, year", longint'(got.year), 0);
        end else begin
          want = owed_dates.pop_front();
          if (got.year != want.year)
            report_mismatch("year", longint'(got.year), longint'(want.year));
          if (got.month != want.month)
            report_mismatch("month", got.month, want.month);
          if (got.day_of_month != want.day_of_month)
            report_mismatch("day_of_month", got.day_of_month, want.day_of_month);
          if (got.hour != want.hour)
            report_mismatch("hour", got.hour, want.hour);
          if (got.minute != want.minute)
            report_mismatch("minute", got.minute, want.minute);
          if (got.second != want.second)
            report_mismatch("second", got.second, want.second);
          if (out_tdata[47:42] != 6'd0)
            report_mismatch("padding", out_tdata[47:42], 0);
          dates_checked++;
        end
      end
    end
    outstanding = owed_dates.size();
  end

endmodule

### dv/julian_day_to_calendar_date_tb.sv
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_tb
// Drives Julian Days into the converter, directed corner dates first and then
// random ones, with random gaps and back-pressure including long hold-offs
// of the output. A separate monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date_tb;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // jd_days, seconds_from_noon
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // year, month, day_of_month, hour, minute, second

  int failures;
  int outstanding;
  int dates_checked;
  int dates_sent;
  int julian_dates;
  int past_midnight;
  int saturated_secs;
  int sender_mode;

  julian_day_to_calendar_date dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  jdcd_date_monitor date_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .failures      (failures),
    .outstanding   (outstanding),
    .dates_checked (dates_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int gap_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Output side: random stalls in changing modes, plus long hold-offs that let
  // the pipeline fill and stall its input.
  initial begin
    int cyc;
    int hold;
    int mode;
    cyc        = 0;
    hold       = 0;
    mode       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 200 == 0) begin
        mode = $urandom_range(0, 2);
      end
      if (cyc == 400 || cyc % 3000 == 0) begin
        hold = 150;
      end
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else if (mode == 1 && $urandom_range(0, 5) == 0 ||
                   mode == 2 && $urandom_range(0, 1) == 0) begin
        out_tready = 1'b0;
        hold       = gap_length() - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge after the date is taken and any gap.
  task automatic send_date(input logic [22:0] jd, input logic [16:0] secs);
    in_tvalid = 1'b1;
    in_tdata  = {secs, jd};
    dates_sent++;
    if (longint'(jd) + (secs >= 17'd43200 ? 1 : 0) < 2299161) julian_dates++;
    if (secs >= 17'd43200) past_midnight++;
    if (secs > 17'd86399) saturated_secs++;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (sender_mode == 1 && $urandom_range(0, 4) == 0 ||
        sender_mode == 2 && $urandom_range(0, 1) == 0) begin
      in_tvalid = 1'b0;
      in_tdata  = 40'({$urandom(), $urandom()});
      repeat (gap_length()) @(negedge clk);
    end
  endtask

  initial begin
    logic [22:0] jd;
    logic [16:0] secs;
    int          pick;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    dates_sent     = 0;
    julian_dates   = 0;
    past_midnight  = 0;
    saturated_secs = 0;
    sender_mode    = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_date(23'd0, 17'd0);
    send_date(23'd0, 17'd43199);
    send_date(23'd0, 17'd43200);
    send_date(23'd0, 17'd86399);
    send_date(23'd0, 17'd86400);
    send_date(23'd0, 17'd131071);
    send_date(23'd8388607, 17'd0);
    send_date(23'd8388607, 17'd43199);
    send_date(23'd8388607, 17'd86399);
    send_date(23'd8388607, 17'd131071);
    send_date(23'd2299159, 17'd86399);
    send_date(23'd2299160, 17'd43199);
    send_date(23'd2299160, 17'd43200);
    send_date(23'd2299161, 17'd0);
    send_date(23'd1721057, 17'd43200);
    send_date(23'd1721423, 17'd43200);
    send_date(23'd2451544, 17'd43200);
    send_date(23'd2451545, 17'd0);
    send_date(23'd2451603, 17'd43200);
    send_date(23'd2451604, 17'd43199);
    send_date(23'd4194304, 17'd65536);
    send_date(23'd5592405, 17'd87381);

    for (int i = 0; i < 1500; i++) begin
      if (i % 100 == 0) begin
        sender_mode = $urandom_range(0, 2);
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        jd = 23'($urandom_range(0, 8388607));
      end else if (pick < 7) begin
        jd = 23'($urandom_range(1700000, 2700000));
      end else if (pick < 9) begin
        jd = 23'($urandom_range(2298761, 2299561));
      end else begin
        jd = 23'($urandom_range(8388207, 8388607));
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        secs = 17'($urandom_range(0, 86399));
      end else if (pick == 7) begin
        secs = 17'($urandom_range(43190, 43210));
      end else if (pick == 8) begin
        secs = ($urandom_range(0, 1) == 0) ? 17'($urandom_range(0, 10))
                                           : 17'($urandom_range(86390, 86399));
      end else begin
        secs = 17'($urandom_range(86400, 131071));
      end
      send_date(jd, secs);
    end
    in_tvalid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Summary: %0d dates sent, %0d checked; %0d on the Julian calendar,",
             dates_sent, dates_checked, julian_dates);
    $display("Summary: %0d past midnight, %0d with seconds beyond the day saturated.",
             past_midnight, saturated_secs);
    if (failures == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### julian_day_to_calendar_date.f
sv/jdcd_pkg.sv
sv/julian_day_to_calendar_date.sv
dv/jdcd_date_monitor.sv
dv/julian_day_to_calendar_date_tb.sv
